@@ rtl/vec3_normalize_unit_macros.svh @@
// Assertion macros shared by the checker
`ifndef VEC3_NORMALIZE_UNIT_MACROS_SVH
`define VEC3_NORMALIZE_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define VN_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked at every clock edge outside reset
`define VN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent in the next cycle, reset not masked
`define VN_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vnorm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vnorm_pkg;

    // Component format
    localparam int CW          = 32;
    localparam int UNIT_FRAC   = 30;
    localparam int OUT_W       = 32;
    localparam int NUM_LANES   = 3;

    // Derived widths
    localparam int SW          = 2 * CW;        // sum of squares
    localparam int LEN_W       = CW;            // floored root
    localparam int QW          = UNIT_FRAC + 1; // quotient magnitude, up to 2^30

    // Pipeline depths
    localparam int SQRT_STAGES = LEN_W;
    localparam int DIV_STAGES  = QW;
    localparam int LAT         = 3 + SQRT_STAGES + DIV_STAGES + 1;

    typedef logic [CW-1:0]    t_mag;
    typedef logic [SW-1:0]    t_sq;
    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_vec_req;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic        [31:0] vec_length;
        logic               zero_length;
    } t_vec_res;

endpackage
`default_nettype wire

@@ rtl/vec3_normalize_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Vector normaliser: one signed Q16.16 three-component vector per request in,
// unit vector (signed Q1.30, truncated toward zero) and floored length
// (unsigned Q16.16) out.
// Request channel: a request is taken at a rising edge with start high and
// busy low. busy is held low: the block is a pipeline and takes one request
// in every cycle, back to back.
// Result channel: o_valid is high for one cycle with the result on o_res;
// the receiver cannot stall, so results leave in request order, one per
// request.
// Path from the taking edge to o_valid: magnitude and square stages, the
// sum register, the square-root stages (one root bit per stage), the
// division stages of the three lanes (one quotient bit per stage) and the
// output register. Throughput is one request a cycle.
// A zero vector gives zero outputs and zero_length set.
// Reset clears the valid pipeline; requests in flight are dropped.
module vec3_normalize_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire vnorm_pkg::t_vec_req  i_req,
    output logic                      busy,
    output logic                      o_valid,
    output vnorm_pkg::t_vec_res       o_res
);
    import vnorm_pkg::*;

    localparam int MAG_DL = SQRT_STAGES + 1;

    logic [31:0] w_raw [NUM_LANES];
    t_mag        w_mag [NUM_LANES];
    logic        w_neg [NUM_LANES];
    t_sq         w_sq  [NUM_LANES];
    logic signed [31:0] w_unit [NUM_LANES];
    t_len        w_root;

    logic [LAT-1:0] r_vld;
    t_sq         r_sum;
    t_mag        r_mag_dl [NUM_LANES][MAG_DL];
    logic        r_neg_dl [NUM_LANES][MAG_DL];
    t_len        r_len_dl [DIV_STAGES];
    t_vec_res    r_res;
    logic        zero;

    assign busy = 1'b0;

    assign w_raw[0] = i_req.vec_x;
    assign w_raw[1] = i_req.vec_y;
    assign w_raw[2] = i_req.vec_z;

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // Per-lane magnitude and square
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_sq
        vnorm_sq_lane u_sq (
            .i_clk (i_clk),
            .i_raw (w_raw[l]),
            .o_mag (w_mag[l]),
            .o_neg (w_neg[l]),
            .o_sq  (w_sq[l])
        );
    end

    // Merge: sum of squares
    always_ff @(posedge i_clk) begin
        r_sum <= w_sq[0] + w_sq[1] + w_sq[2];
    end

    vnorm_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_sum  (r_sum),
        .o_root (w_root)
    );

    // Magnitudes wait for the root
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_dl
        always_ff @(posedge i_clk) begin
            r_mag_dl[l][0] <= w_mag[l];
            r_neg_dl[l][0] <= w_neg[l];
            for (int k = 1; k < MAG_DL; k++) begin
                r_mag_dl[l][k] <= r_mag_dl[l][k-1];
                r_neg_dl[l][k] <= r_neg_dl[l][k-1];
            end
        end

        vnorm_div_lane u_div (
            .i_clk  (i_clk),
            .i_mag  (r_mag_dl[l][MAG_DL-1]),
            .i_neg  (r_neg_dl[l][MAG_DL-1]),
            .i_len  (w_root),
            .o_unit (w_unit[l])
        );
    end

    // Length waits for the quotients
    always_ff @(posedge i_clk) begin
        r_len_dl[0] <= w_root;
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_len_dl[k] <= r_len_dl[k-1];
        end
    end

    assign zero = (r_len_dl[DIV_STAGES-1] == '0);

    // Output register, zero vector masked
    always_ff @(posedge i_clk) begin
        r_res.unit_x      <= zero ? '0 : w_unit[0];
        r_res.unit_y      <= zero ? '0 : w_unit[1];
        r_res.unit_z      <= zero ? '0 : w_unit[2];
        r_res.vec_length  <= 32'(r_len_dl[DIV_STAGES-1]);
        r_res.zero_length <= zero;
    end

    assign o_valid = r_vld[LAT-1];
    assign o_res   = r_res;
endmodule
`default_nettype wire

@@ rtl/vnorm_sq_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vnorm_sq_lane (
    input  wire logic          i_clk,
    input  wire logic [31:0]   i_raw,
    output vnorm_pkg::t_mag    o_mag,
    output logic               o_neg,
    output vnorm_pkg::t_sq     o_sq
);
    import vnorm_pkg::*;

    t_mag v;
    t_mag r_mag1, r_mag2;
    logic r_neg1, r_neg2;
    t_sq  r_sq;

    assign v = i_raw[CW-1:0];

    // Stage 1: magnitude and sign
    always_ff @(posedge i_clk) begin
        r_neg1 <= v[CW-1];
        r_mag1 <= v[CW-1] ? (~v + t_mag'(1)) : v;
    end

    // Stage 2: square
    always_ff @(posedge i_clk) begin
        r_sq   <= SW'(r_mag1) * SW'(r_mag1);
        r_mag2 <= r_mag1;
        r_neg2 <= r_neg1;
    end

    assign o_mag = r_mag2;
    assign o_neg = r_neg2;
    assign o_sq  = r_sq;
endmodule
`default_nettype wire

@@ rtl/vnorm_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vnorm_isqrt (
    input  wire logic            i_clk,
    input  wire vnorm_pkg::t_sq  i_sum,
    output vnorm_pkg::t_len      o_root
);
    import vnorm_pkg::*;

    localparam int RW = CW + 2;

    logic [RW-1:0]    r_rem  [SQRT_STAGES];
    logic [LEN_W-1:0] r_root [SQRT_STAGES];
    logic [SW-1:0]    r_rad  [SQRT_STAGES];

    // One root bit per stage, two radicand bits consumed
    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [RW-1:0]    rem_in;
        logic [LEN_W-1:0] root_in;
        logic [SW-1:0]    rad_in;
        logic [RW+1:0]    cur, trial, diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_sum;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign rad_in  = r_rad[s-1];
        end

        assign cur   = {rem_in, rad_in[SW-1:SW-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = cur - trial;
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
            r_root[s] <= {root_in[LEN_W-2:0], ge};
            r_rad[s]  <= {rad_in[SW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
endmodule
`default_nettype wire

@@ rtl/vnorm_div_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vnorm_div_lane (
    input  wire logic               i_clk,
    input  wire vnorm_pkg::t_mag    i_mag,
    input  wire logic               i_neg,
    input  wire vnorm_pkg::t_len    i_len,
    output logic signed [31:0]      o_unit
);
    import vnorm_pkg::*;

    logic [CW-1:0]    r_rem [DIV_STAGES];
    logic [QW-1:0]    r_q   [DIV_STAGES];
    logic [LEN_W-1:0] r_len [DIV_STAGES];
    logic             r_neg [DIV_STAGES];
    logic [OUT_W-1:0] qx;

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [CW:0]      t;
        logic [CW:0]      diff;
        logic [QW-1:0]    q_in;
        logic [LEN_W-1:0] len_in;
        logic             neg_in;
        logic             ge;

        if (s == 0) begin : g_first
            assign t      = {1'b0, i_mag};
            assign q_in   = '0;
            assign len_in = i_len;
            assign neg_in = i_neg;
        end else begin : g_next
            assign t      = {r_rem[s-1], 1'b0};
            assign q_in   = r_q[s-1];
            assign len_in = r_len[s-1];
            assign neg_in = r_neg[s-1];
        end

        assign ge   = (t >= {1'b0, len_in});
        assign diff = t - {1'b0, len_in};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? diff[CW-1:0] : t[CW-1:0];
            r_q[s]   <= {q_in[QW-2:0], ge};
            r_len[s] <= len_in;
            r_neg[s] <= neg_in;
        end
    end

    // Apply sign
    assign qx     = OUT_W'(r_q[DIV_STAGES-1]);
    assign o_unit = r_neg[DIV_STAGES-1] ? signed'(~qx + OUT_W'(1)) : signed'(qx);
endmodule
`default_nettype wire

@@ rtl/vnorm_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "vec3_normalize_unit_macros.svh"
module vnorm_chk (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire vnorm_pkg::t_vec_req  i_req,
    input  wire logic                 busy,
    input  wire logic                 o_valid,
    input  wire vnorm_pkg::t_vec_res  o_res
);
    logic req_seen;
    logic zl_ok;
    logic units_zero;
    logic x_in_range;

    assign req_seen   = start & ~busy & (i_req.vec_x == i_req.vec_x);
    assign zl_ok      = o_res.zero_length == (o_res.vec_length == 32'd0);
    assign units_zero = (o_res.unit_x == 32'sd0) && (o_res.unit_y == 32'sd0) &&
                        (o_res.unit_z == 32'sd0);
    assign x_in_range = (o_res.unit_x <= 32'sd1073741824) &&
                        (o_res.unit_x >= -32'sd1073741824);

    // No result straight after reset
    `VN_ASSERT_NEXT(a_rst_quiet, i_clk, !i_rst_n, !o_valid, "result right after reset")
    // Flag agrees with the length
    `VN_ASSERT_IMPL(a_zero_flag, i_clk, i_rst_n, o_valid, zl_ok, "zero flag mismatch")
    // Zero vector gives zero components
    `VN_ASSERT_IMPL(a_zero_unit, i_clk, i_rst_n, o_valid && o_res.zero_length, units_zero, "zero vector not zero")
    // Unit x component stays within one
    `VN_ASSERT_IMPL(a_unit_range, i_clk, i_rst_n, o_valid, x_in_range, "unit x out of range")
    // Busy never coincides with a taken request (true by construction: a taken request needs busy low)
    `VN_ASSERT_ALWAYS(a_no_busy, i_clk, i_rst_n, !busy || !req_seen, "busy raised")
endmodule

bind vec3_normalize_unit vnorm_chk u_vnorm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
`default_nettype wire
